// ===== design/pfim_pkg.sv =====
// ----------------------------------------------------------------------------
// pfim_pkg
// Shared types, widths and helpers for the point feature interaction matrix.
// ----------------------------------------------------------------------------
package pfim_pkg;

    localparam int U_W     = 16;
    localparam int Z_W     = 24;
    localparam int F_W     = 20;
    localparam int ENTRY_W = 40;
    localparam int DEN_W   = 24;
    localparam int ROWS    = 2;
    localparam int COLS    = 6;

    localparam logic [F_W-1:0]     FOCAL_RESET  = F_W'(221184);
    localparam logic [ENTRY_W-1:0] ENTRY_MAXPOS = {1'b0, {(ENTRY_W-1){1'b1}}};
    localparam logic [ENTRY_W-1:0] ENTRY_MAXNEG = {1'b1, {(ENTRY_W-1){1'b0}}};

    typedef logic [ENTRY_W-1:0] entry_t;

    // one step of a long-division lane
    typedef struct packed {
        logic [DEN_W-1:0]   rem;
        logic [ENTRY_W-1:0] word;
        logic [DEN_W-1:0]   den;
        logic               ovf;
    } div_lane_t;

    // item data that rides beside the divider lanes
    typedef struct packed {
        logic           u_neg;
        logic           v_neg;
        logic           err;
        logic [U_W-1:0] u_mag;
        logic [U_W-1:0] v_mag;
    } item_tag_t;

    // sign and magnitude to saturated two's complement
    function automatic entry_t pack_entry(input logic neg, input logic ovf,
                                          input entry_t mag);
        entry_t res;
        if (neg) begin
            if (ovf || mag[ENTRY_W-1]) begin
                res = ENTRY_MAXNEG;
            end else begin
                res = entry_t'(~mag + entry_t'(1));
            end
        end else begin
            if (ovf || mag[ENTRY_W-1]) begin
                res = ENTRY_MAXPOS;
            end else begin
                res = mag;
            end
        end
        return res;
    endfunction

endpackage

// ===== design/point_feature_interaction_matrix.sv =====
// ----------------------------------------------------------------------------
// point_feature_interaction_matrix
// 2x6 image Jacobian of a point feature, one row per output transaction.
//
//   port group   dir  contents
//   s_*          in   pixel_u, pixel_v, depth
//   m_*          out  one matrix row, row 0 then row 1
//   cfg_*        in   focal_length write
//
// new items enter while earlier ones are still in the cells; the two output
// rows share one output register, which takes the next item when row 1 is taken.
// the six quotients come from six rows of 40 division cells, one bit each.
// an item held by m_tready freezes the whole pipeline; s_tready drops with it.
// aresetn clears valid flags and restores focal_length to 864.0.
// ----------------------------------------------------------------------------
module point_feature_interaction_matrix #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [19:0]  cfg_wdata,     // focal_length
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,       // pixel_u, pixel_v, depth
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata,       // entry_vx, vy, vz, wx, wy, wz
    output logic [1:0]   m_tuser,       // row_index, depth_error
    output logic         m_tlast        // last_row
);
    import pfim_pkg::*;

    localparam int F     = OUT_FRAC_BITS;
    localparam int NUM_W = 34 + F;
    localparam int LAT   = ENTRY_W;

    logic [F_W-1:0] focal_reg;

    logic               adv;
    logic               s_acc;

    // stage 0: products
    logic               v0_reg;
    item_tag_t          tag0_reg;
    logic [Z_W-1:0]     z0_reg;
    logic [F_W-1:0]     f0_reg;
    logic [2*U_W-1:0]   uv0_reg, uu0_reg, vv0_reg;
    logic [2*F_W-1:0]   ff0_reg;
    item_tag_t          tag0_next;
    logic [U_W-1:0]     in_u, in_v;
    logic [Z_W-1:0]     in_z;
    logic [F_W-1:0]     f_eff;

    // stage 1: numerators
    logic               v1_reg;
    item_tag_t          tag1_reg;
    logic [NUM_W-1:0]   num_reg [COLS];
    logic [DEN_W-1:0]   den_reg [COLS];
    logic [NUM_W-1:0]   num_next [COLS];
    logic [DEN_W-1:0]   dz, df;

    // tag line beside the cells
    logic               vl_reg [LAT];
    item_tag_t          tl_reg [LAT];

    entry_t             quo [COLS];
    logic               ovf [COLS];

    // output
    logic               full_reg;
    logic               row_reg;
    logic               err_reg;
    entry_t             row0_reg [COLS];
    entry_t             row1_reg [COLS];
    entry_t             row0_next [COLS];
    entry_t             row1_next [COLS];
    logic               done;
    logic               load;
    item_tag_t          tt;
    logic               uvn;
    entry_t             us, vs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg <= FOCAL_RESET;
        end else if (cfg_we) begin
            focal_reg <= cfg_wdata;
        end
    end

    assign done     = full_reg && m_tready && row_reg;
    assign adv      = !vl_reg[LAT-1] || !full_reg || done;
    assign load     = vl_reg[LAT-1] && adv;
    assign s_tready = adv;
    assign s_acc    = s_tvalid && adv;

    always_comb begin
        in_u  = s_tdata[15:0];
        in_v  = s_tdata[31:16];
        in_z  = s_tdata[55:32];
        f_eff = (focal_reg == '0) ? F_W'(1) : focal_reg;
        tag0_next.u_neg = in_u[U_W-1];
        tag0_next.v_neg = in_v[U_W-1];
        tag0_next.err   = (in_z == '0);
        tag0_next.u_mag = in_u[U_W-1] ? U_W'(-in_u) : in_u;
        tag0_next.v_mag = in_v[U_W-1] ? U_W'(-in_v) : in_v;
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            for (int i = 0; i < LAT; i++) begin
                vl_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v0_reg    <= s_acc;
            v1_reg    <= v0_reg;
            vl_reg[0] <= v1_reg;
            for (int i = 1; i < LAT; i++) begin
                vl_reg[i] <= vl_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag0_reg <= tag0_next;
            z0_reg   <= in_z;
            f0_reg   <= f_eff;
            uv0_reg  <= (2*U_W)'(tag0_next.u_mag) * (2*U_W)'(tag0_next.v_mag);
            uu0_reg  <= (2*U_W)'(tag0_next.u_mag) * (2*U_W)'(tag0_next.u_mag);
            vv0_reg  <= (2*U_W)'(tag0_next.v_mag) * (2*U_W)'(tag0_next.v_mag);
            ff0_reg  <= (2*F_W)'(f_eff) * (2*F_W)'(f_eff);
            tag1_reg <= tag0_reg;
            num_reg  <= num_next;
            for (int c = 0; c < COLS; c++) begin
                den_reg[c] <= (c < 3) ? dz : df;
            end
            tl_reg[0] <= tag1_reg;
            for (int i = 1; i < LAT; i++) begin
                tl_reg[i] <= tl_reg[i-1];
            end
        end
    end

    // columns: 0 f/Z, 1 u/Z, 2 v/Z, 3 uv/f, 4 (f2+u2)/f, 5 (f2+v2)/f
    always_comb begin
        dz = z0_reg;
        df = DEN_W'(f0_reg);
        num_next[0] = (NUM_W'(f0_reg) << (8 + F)) + NUM_W'(dz >> 1);
        num_next[1] = (NUM_W'(tag0_reg.u_mag) << (12 + F)) + NUM_W'(dz >> 1);
        num_next[2] = (NUM_W'(tag0_reg.v_mag) << (12 + F)) + NUM_W'(dz >> 1);
        num_next[3] = (NUM_W'(uv0_reg) << F) + NUM_W'(df >> 1);
        num_next[4] = ((NUM_W'(ff0_reg) + (NUM_W'(uu0_reg) << 8)) << (F - 8))
                    + NUM_W'(df >> 1);
        num_next[5] = ((NUM_W'(ff0_reg) + (NUM_W'(vv0_reg) << 8)) << (F - 8))
                    + NUM_W'(df >> 1);
    end

    for (genvar c = 0; c < COLS; c++) begin : g_div
        pfim_div_chain #(
            .NUM_W (NUM_W)
        ) u_chain (
            .aclk (aclk),
            .en   (adv),
            .num  (num_reg[c]),
            .den  (den_reg[c]),
            .quo  (quo[c]),
            .ovf  (ovf[c])
        );
    end

    always_comb begin
        tt  = tl_reg[LAT-1];
        uvn = tt.u_neg ^ tt.v_neg;
        us  = entry_t'(tt.u_mag) << (F - 4);
        vs  = entry_t'(tt.v_mag) << (F - 4);
        row0_next[0] = pack_entry(1'b1, ovf[0], quo[0]);
        row0_next[1] = '0;
        row0_next[2] = pack_entry(tt.u_neg, ovf[1], quo[1]);
        row0_next[3] = pack_entry(uvn, ovf[3], quo[3]);
        row0_next[4] = pack_entry(1'b1, ovf[4], quo[4]);
        row0_next[5] = pack_entry(tt.v_neg, 1'b0, vs);
        row1_next[0] = '0;
        row1_next[1] = pack_entry(1'b1, ovf[0], quo[0]);
        row1_next[2] = pack_entry(tt.v_neg, ovf[2], quo[2]);
        row1_next[3] = pack_entry(1'b0, ovf[5], quo[5]);
        row1_next[4] = pack_entry(!uvn, ovf[3], quo[3]);
        row1_next[5] = pack_entry(!tt.u_neg, 1'b0, us);
        if (tt.err) begin
            for (int c = 0; c < COLS; c++) begin
                row0_next[c] = '0;
                row1_next[c] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            row_reg  <= 1'b0;
        end else begin
            if (load) begin
                full_reg <= 1'b1;
                row_reg  <= 1'b0;
            end else if (done) begin
                full_reg <= 1'b0;
                row_reg  <= 1'b0;
            end else if (full_reg && m_tready) begin
                row_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            err_reg  <= tt.err;
            row0_reg <= row0_next;
            row1_reg <= row1_next;
        end
    end

    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            m_tdata[c*ENTRY_W +: ENTRY_W] = row_reg ? row1_reg[c] : row0_reg[c];
        end
    end

    assign m_tvalid = full_reg;
    assign m_tuser  = {err_reg, row_reg};
    assign m_tlast  = row_reg;

endmodule

// ===== design/pfim_div_cell.sv =====
// ----------------------------------------------------------------------------
// pfim_div_cell
// One restoring-division step: develops one quotient bit and passes it on.
// ----------------------------------------------------------------------------
module pfim_div_cell (
    input  logic                aclk,
    input  logic                en,
    input  pfim_pkg::div_lane_t lane_in,
    output pfim_pkg::div_lane_t lane_out
);
    import pfim_pkg::*;

    div_lane_t          lane_reg;
    div_lane_t          lane_next;
    logic [DEN_W:0]     rem_sh;
    logic [DEN_W:0]     rem_sub;
    logic               ge;

    always_comb begin
        rem_sh  = {lane_in.rem, lane_in.word[ENTRY_W-1]};
        ge      = rem_sh >= {1'b0, lane_in.den};
        rem_sub = rem_sh - {1'b0, lane_in.den};
        lane_next      = lane_in;
        lane_next.rem  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        lane_next.word = {lane_in.word[ENTRY_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// ===== design/pfim_div_chain.sv =====
// ----------------------------------------------------------------------------
// pfim_div_chain
// Row of division cells giving a 40-bit quotient with an overflow flag.
// ----------------------------------------------------------------------------
module pfim_div_chain #(
    parameter int NUM_W = 50
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [NUM_W-1:0]           num,
    input  logic [pfim_pkg::DEN_W-1:0] den,
    output pfim_pkg::entry_t           quo,
    output logic                       ovf
);
    import pfim_pkg::*;

    localparam int HI_W = NUM_W - ENTRY_W;

    logic [HI_W+DEN_W-1:0] hi_x;
    div_lane_t             lane_init;
    div_lane_t             lanes [ENTRY_W];

    always_comb begin
        hi_x           = {{DEN_W{1'b0}}, num[NUM_W-1:ENTRY_W]};
        lane_init.rem  = hi_x[DEN_W-1:0];
        lane_init.word = num[ENTRY_W-1:0];
        lane_init.den  = den;
        lane_init.ovf  = hi_x >= (HI_W+DEN_W)'(den);
    end

    for (genvar i = 0; i < ENTRY_W; i++) begin : g_cell
        if (i == 0) begin : g_first
            pfim_div_cell u_cell (
                .aclk     (aclk),
                .en       (en),
                .lane_in  (lane_init),
                .lane_out (lanes[i])
            );
        end else begin : g_next
            pfim_div_cell u_cell (
                .aclk     (aclk),
                .en       (en),
                .lane_in  (lanes[i-1]),
                .lane_out (lanes[i])
            );
        end
    end

    assign quo = lanes[ENTRY_W-1].word;
    assign ovf = lanes[ENTRY_W-1].ovf;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the point feature interaction matrix block against its own
// predictor of the two matrix rows. Stimulus covers corner items, several
// focal lengths, random items under random idling and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import pfim_pkg::*;

    typedef struct {
        logic   row;
        entry_t col [COLS];
        logic   err;
        logic   last;
    } row_result_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [19:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;       // pixel_u, pixel_v, depth
    logic         m_tvalid;
    logic         m_tready;
    logic [239:0] m_tdata;       // entry_vx, vy, vz, wx, wy, wz
    logic [1:0]   m_tuser;       // row_index, depth_error
    logic         m_tlast;

    row_result_t   pending_rows [$];
    logic [F_W-1:0] focal_model;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_cycles;
    int            fail_count;
    int            quiet_cycles;

    localparam int LATENCY  = 60;
    localparam int WD_LIMIT = 20000;

    point_feature_interaction_matrix u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic entry_t saturate(input logic neg, input logic [63:0] mag);
        entry_t res;
        if (mag == 0) begin
            res = '0;
        end else if (!neg) begin
            res = (mag > 64'(ENTRY_MAXPOS)) ? ENTRY_MAXPOS : mag[ENTRY_W-1:0];
        end else if (mag >= 64'(ENTRY_MAXNEG)) begin
            res = ENTRY_MAXNEG;
        end else begin
            res = entry_t'(-mag);
        end
        return res;
    endfunction

    function automatic logic [63:0] rdiv(input logic [63:0] num, input logic [63:0] den);
        return (num + (den >> 1)) / den;
    endfunction

    task automatic predict_rows(input logic [15:0] u, input logic [15:0] v,
                                input logic [23:0] z);
        row_result_t r0, r1;
        logic [63:0] fr, um, vm, fz, uz, vz, uvf, fu, fv, us, vs;
        logic        un, vn, uvn, err;
        un  = u[15];
        vn  = v[15];
        um  = un ? 64'(17'h10000 - u) : 64'(u);
        vm  = vn ? 64'(17'h10000 - v) : 64'(v);
        fr  = (focal_model == 0) ? 64'd1 : 64'(focal_model);
        err = (z == 0);
        uvn = un ^ vn;
        r0.row = 1'b0; r0.err = err; r0.last = 1'b0;
        r1.row = 1'b1; r1.err = err; r1.last = 1'b1;
        for (int c = 0; c < COLS; c++) begin
            r0.col[c] = '0;
            r1.col[c] = '0;
        end
        if (!err) begin
            fz  = rdiv(fr << 24, 64'(z));
            uz  = rdiv(um << 28, 64'(z));
            vz  = rdiv(vm << 28, 64'(z));
            uvf = rdiv((um * vm) << 16, fr);
            fu  = rdiv((fr * fr + ((um * um) << 8)) << 8, fr);
            fv  = rdiv((fr * fr + ((vm * vm) << 8)) << 8, fr);
            us  = um << 12;
            vs  = vm << 12;
            r0.col[0] = saturate(1'b1, fz);
            r0.col[2] = saturate(un, uz);
            r0.col[3] = saturate(uvn, uvf);
            r0.col[4] = saturate(1'b1, fu);
            r0.col[5] = saturate(vn, vs);
            r1.col[1] = saturate(1'b1, fz);
            r1.col[2] = saturate(vn, vz);
            r1.col[3] = saturate(1'b0, fv);
            r1.col[4] = saturate(!uvn, uvf);
            r1.col[5] = saturate(!un, us);
        end
        pending_rows.push_back(r0);
        pending_rows.push_back(r1);
    endtask

    // sender: called at a falling edge, returns at a falling edge
    task automatic send_point(input logic [15:0] u, input logic [15:0] v,
                              input logic [23:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {z, v, u};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_rows(u, v, z);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (pending_rows.size() != 0) @(negedge aclk);
        repeat (LATENCY) @(negedge aclk);
    endtask

    task automatic write_focal(input logic [19:0] f);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = f;
        @(negedge aclk);
        cfg_we      = 1'b0;
        focal_model = f;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom_range(200)) - 16'd100;
            1: return 16'($urandom_range(65535));
            2: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                        : 16'h8000 + 16'($urandom_range(3));
            default: return 16'($urandom_range(8000)) - 16'd4000;
        endcase
    endfunction

    function automatic logic [23:0] rand_depth();
        case ($urandom_range(9))
            0: return 24'd0;
            1: return 24'($urandom_range(15));
            2: return 24'($urandom_range(24'hffffff));
            3: return 24'hffffff - 24'($urandom_range(3));
            default: return 24'($urandom_range(24'h40000, 24'h1000));
        endcase
    endfunction

    task automatic test_corners();
        logic [15:0] coords [5] = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000};
        for (int i = 0; i < 5; i++) begin
            send_point(coords[i], coords[4 - i], 24'h010000);
        end
        send_point(16'h8000, 16'h8000, 24'd1);
        send_point(16'h7fff, 16'h8000, 24'd1);
        send_point(16'h1234, 16'h5678, 24'd0);
        send_point(16'h8000, 16'h7fff, 24'd0);
        send_point(16'h0010, 16'hfff0, 24'hffffff);
        send_point(16'haaaa, 16'h5555, 24'h555555);
        send_point(16'h5555, 16'haaaa, 24'haaaaaa);
        send_point(16'h0018, 16'hffe8, 24'h018000);
    endtask

    task automatic test_focal_settings();
        logic [19:0] focals [5] = '{20'd1, 20'hfffff, 20'd0, 20'h55555, FOCAL_RESET};
        for (int i = 0; i < 5; i++) begin
            write_focal(focals[i]);
            send_point(16'h7fff, 16'h8000, 24'd1);
            send_point(16'h8000, 16'h8000, 24'hffffff);
            send_point(16'h0001, 16'hffff, 24'h010000);
            send_point(rand_coord(), rand_coord(), rand_depth());
        end
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 99) begin
                write_focal(($urandom_range(3) == 0) ? 20'($urandom_range(20'hfffff))
                                                     : 20'($urandom_range(80000, 100)));
            end
            send_point(rand_coord(), rand_coord(), rand_depth());
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 60; i++) begin
            send_point(rand_coord(), rand_coord(), rand_depth());
        end
        drain();
        for (int i = 0; i < 20; i++) begin
            send_point(rand_coord(), rand_coord(), rand_depth());
        end
    endtask

    // receiver ready and long hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        row_result_t exp_row;
        entry_t      got;
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WD_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected transaction, actual data %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                fail_count = fail_count + 1;
            end else begin
                exp_row = pending_rows.pop_front();
                for (int c = 0; c < COLS; c++) begin
                    got = m_tdata[c*ENTRY_W +: ENTRY_W];
                    if (got !== exp_row.col[c]) begin
                        $display("%0t: row %0d column %0d expected %h actual %h",
                                 $time, exp_row.row, c, exp_row.col[c], got);
                        fail_count = fail_count + 1;
                    end
                end
                if (m_tuser !== {exp_row.err, exp_row.row} || m_tlast !== exp_row.last) begin
                    $display("%0t: flags expected user %b last %b actual user %b last %b",
                             $time, {exp_row.err, exp_row.row}, exp_row.last,
                             m_tuser, m_tlast);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        hold_cycles   = 0;
        fail_count    = 0;
        quiet_cycles  = 0;
        focal_model   = FOCAL_RESET;
        send_idle_pct = 22;
        recv_idle_pct = 46;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_corners();
        test_focal_settings();
        test_random(400);
        send_idle_pct = 46;
        recv_idle_pct = 22;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(400);

        drain();
        if (fail_count == 0 && pending_rows.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
